### design/two_party_session_slot_table_macros.svh
// assertion macros for the session slot table checker
// both sample on i_clk and stay quiet while i_rst_n is low
`ifndef TWO_PARTY_SESSION_SLOT_TABLE_MACROS_SVH
`define TWO_PARTY_SESSION_SLOT_TABLE_MACROS_SVH

// same-cycle implication
`define TPST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tpst_pkg.sv
// shared types, codes and the microcode table of the session slot table
// no dependencies
`timescale 1ns / 1ps

package tpst_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int ID_BITS_DEF   = 16;
    localparam int PID_W         = 16;
    localparam int ID_EXT_W      = 32;
    localparam int CMD_W         = 3;
    localparam int IDX_OUT_W     = 4;
    localparam int STEP_W        = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 3'd0,
        CMD_JOIN   = 3'd1,
        CMD_ROLE   = 3'd2,
        CMD_FIND   = 3'd3,
        CMD_LEAVE  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_WAITING = 2'd1,
        ST_FULL    = 2'd2
    } t_slot_st;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_FAIL,
        OP_COMMIT,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_UNKNOWN,
        C_HIT,
        C_SCAN_BUSY,
        C_OUT_BUSY
    } t_cond;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_WAIT   = 3'd0;
    localparam t_step STEP_DISP   = 3'd1;
    localparam t_step STEP_SCAN   = 3'd2;
    localparam t_step STEP_FAIL   = 3'd3;
    localparam t_step STEP_COMMIT = 3'd4;
    localparam t_step STEP_EMIT   = 3'd5;

    // hold wins over jump, jump wins over fall-through
    typedef struct packed {
        t_op   op;
        t_cond hold;
        t_cond jump;
        t_step target;
    } t_ctl;

    typedef struct packed {
        logic no_input;
        logic unknown;
        logic hit;
        logic scan_busy;
        logic out_busy;
    } t_flags;

    function automatic t_ctl ctl_rom(input t_step step);
        t_ctl w;
        w = '{op: OP_NONE, hold: C_NEVER, jump: C_ALWAYS, target: STEP_WAIT};
        case (step)
            STEP_WAIT:   w = '{op: OP_LOAD,   hold: C_NO_INPUT,  jump: C_NEVER,
                               target: STEP_WAIT};
            STEP_DISP:   w = '{op: OP_NONE,   hold: C_NEVER,     jump: C_UNKNOWN,
                               target: STEP_FAIL};
            STEP_SCAN:   w = '{op: OP_SCAN,   hold: C_SCAN_BUSY, jump: C_HIT,
                               target: STEP_COMMIT};
            STEP_FAIL:   w = '{op: OP_FAIL,   hold: C_NEVER,     jump: C_ALWAYS,
                               target: STEP_EMIT};
            STEP_COMMIT: w = '{op: OP_COMMIT, hold: C_NEVER,     jump: C_NEVER,
                               target: STEP_WAIT};
            STEP_EMIT:   w = '{op: OP_EMIT,   hold: C_OUT_BUSY,  jump: C_ALWAYS,
                               target: STEP_WAIT};
            default:     w = '{op: OP_NONE,   hold: C_NEVER,     jump: C_ALWAYS,
                               target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

### design/two_party_session_slot_table.sv
// session slot table: top level with slot storage and scan datapath
// depends on tpst_pkg and tpst_useq
//
// usage
// - input channel: i_valid / o_stall carry one command word (i_command,
//   i_player_id); a word is taken when i_valid is high and o_stall low
// - output channel: o_valid / i_stall carry one result word per command
//   (o_success, o_slot_index, o_is_guest)
// - one command is worked at a time; o_stall is low only while the
//   sequencer waits for a new command
// - timing: an accepted command goes through the dispatch step, the scan
//   (one slot per cycle through the registered id memory read port), then
//   the commit step on a hit or the fail step otherwise, then the emit step;
//   an unknown command goes from dispatch straight to fail; the input frees
//   again once the emit step has loaded the output register
// - a new command may be taken while the previous result still sits in
//   the output register; the emit step then waits until that word leaves
// - receiver stall: the output word holds steady until taken
// - reset: synchronous, active low; all slots return to empty at once,
//   id memories keep stale data that empty slots never expose
`timescale 1ns / 1ps

module two_party_session_slot_table #(
    parameter int NUM_SLOTS = tpst_pkg::NUM_SLOTS_DEF,
    parameter int ID_BITS   = tpst_pkg::ID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tpst_pkg::CMD_W-1:0]    i_command,
    input  logic [tpst_pkg::PID_W-1:0]    i_player_id,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_success,
    output logic [tpst_pkg::IDX_OUT_W-1:0] o_slot_index,
    output logic                          o_is_guest
);
    import tpst_pkg::*;

    localparam int PTR_W = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // sequencer
    t_ctl   w_ctl;
    t_flags w_flags;

    // command latch
    logic [CMD_W-1:0]   r_cmd;
    logic [ID_BITS-1:0] r_id;
    logic [ID_EXT_W-1:0] w_pid_ext;

    // slot storage: status in flops (cleared by reset), ids in memories
    t_slot_st           r_status [NUM_SLOTS];
    logic [ID_BITS-1:0] r_owner_mem [NUM_SLOTS];
    logic [ID_BITS-1:0] r_guest_mem [NUM_SLOTS];

    // scan pointer and read stage
    logic [PTR_W-1:0]   r_ptr;
    logic [PTR_W-1:0]   n_ptr;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_rd_en;
    logic               w_scan_adv;
    logic               r_q_vld;
    logic               n_q_vld;
    logic [IDX_W-1:0]   r_q_idx;
    t_slot_st           r_q_st;
    logic [ID_BITS-1:0] r_own_rd;
    logic [ID_BITS-1:0] r_gst_rd;

    // match logic
    logic w_own_hit;
    logic w_gst_hit;
    logic w_hit;
    logic w_end;
    logic w_is_match_cmd;

    // result and output registers
    logic                 r_res_ok;
    logic [IDX_OUT_W-1:0] r_res_idx;
    logic                 r_res_guest;
    logic [IDX_W+IDX_OUT_W-1:0] w_idx_wide;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 w_in_acc;
    logic                 w_out_acc;
    logic                 w_out_busy;
    logic                 w_emit;
    logic                 w_commit;

    tpst_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    // handshakes
    assign o_stall    = (w_ctl.op != OP_LOAD);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_acc  = r_out_valid && !i_stall;
    assign w_out_busy = r_out_valid && i_stall;
    assign w_emit     = (w_ctl.op == OP_EMIT) && !w_out_busy;
    assign w_commit   = (w_ctl.op == OP_COMMIT);

    // only the low ID_BITS of the player id take part
    assign w_pid_ext = ID_EXT_W'(i_player_id);

    // slot test on the word read in the previous cycle
    assign w_own_hit = (r_q_st != ST_EMPTY) && (r_own_rd == r_id);
    assign w_gst_hit = (r_q_st == ST_FULL) && (r_gst_rd == r_id);
    assign w_is_match_cmd = (r_cmd == CMD_ROLE) || (r_cmd == CMD_FIND)
                         || (r_cmd == CMD_LEAVE);

    always_comb begin
        w_hit = 1'b0;
        if (r_q_vld) begin
            case (r_cmd)
                CMD_CREATE: w_hit = (r_q_st == ST_EMPTY);
                CMD_JOIN:   w_hit = (r_q_st == ST_WAITING);
                CMD_ROLE,
                CMD_FIND,
                CMD_LEAVE:  w_hit = w_own_hit || w_gst_hit;
                default:    w_hit = 1'b0;
            endcase
        end
    end

    // every slot issued and the last one tested
    assign w_end = !r_q_vld && (r_ptr == PTR_W'(NUM_SLOTS));

    assign w_flags = '{
        no_input:  !i_valid,
        unknown:   (r_cmd > CMD_LEAVE),
        hit:       w_hit,
        scan_busy: !w_hit && !w_end,
        out_busy:  w_out_busy
    };

    // scan issue: one slot address per cycle, frozen on a hit
    assign w_scan_adv = (w_ctl.op == OP_SCAN) && !w_hit;
    assign w_rd_en    = w_scan_adv && (r_ptr < PTR_W'(NUM_SLOTS));
    assign w_rd_addr  = r_ptr[IDX_W-1:0];

    always_comb begin
        n_ptr   = r_ptr;
        n_q_vld = r_q_vld;
        if (w_in_acc) begin
            n_ptr   = '0;
            n_q_vld = 1'b0;
        end else if (w_scan_adv) begin
            n_q_vld = w_rd_en;
            if (w_rd_en) begin
                n_ptr = r_ptr + PTR_W'(1);
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !w_out_acc;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_q_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ptr       <= n_ptr;
            r_q_vld     <= n_q_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // slot status: all empty at reset, updated at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_status[s] <= ST_EMPTY;
            end
        end else if (w_commit) begin
            case (r_cmd)
                CMD_CREATE: r_status[r_q_idx] <= ST_WAITING;
                CMD_JOIN:   r_status[r_q_idx] <= ST_FULL;
                CMD_LEAVE:  r_status[r_q_idx] <= ST_EMPTY;
                default:    r_status[r_q_idx] <= r_q_st;
            endcase
        end
    end

    // id memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (w_commit && (r_cmd == CMD_CREATE)) begin
            r_owner_mem[r_q_idx] <= r_id;
        end
        if (w_rd_en) begin
            r_own_rd <= r_owner_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit && (r_cmd == CMD_JOIN)) begin
            r_guest_mem[r_q_idx] <= r_id;
        end
        if (w_rd_en) begin
            r_gst_rd <= r_guest_mem[w_rd_addr];
        end
    end

    // command latch and read stage payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd <= i_command;
            r_id  <= w_pid_ext[ID_BITS-1:0];
        end
        if (w_rd_en) begin
            r_q_idx <= w_rd_addr;
            r_q_st  <= r_status[w_rd_addr];
        end
    end

    // reported index keeps its low four bits
    assign w_idx_wide = {{IDX_OUT_W{1'b0}}, r_q_idx};

    always_ff @(posedge i_clk) begin
        if (w_ctl.op == OP_FAIL) begin
            r_res_ok    <= 1'b0;
            r_res_idx   <= '0;
            r_res_guest <= 1'b0;
        end else if (w_commit) begin
            r_res_ok    <= 1'b1;
            r_res_idx   <= w_idx_wide[IDX_OUT_W-1:0];
            // guest flag only for find with role, and only when the owner missed
            r_res_guest <= w_is_match_cmd && (r_cmd == CMD_ROLE) && !w_own_hit;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_success    <= r_res_ok;
            o_slot_index <= r_res_idx;
            o_is_guest   <= r_res_guest;
        end
    end

    assign o_valid = r_out_valid;

endmodule

### design/tpst_useq.sv
// microcode sequencer: step counter, control table lookup, jump logic
// depends on tpst_pkg
`timescale 1ns / 1ps

module tpst_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tpst_pkg::t_flags i_flags,
    output tpst_pkg::t_ctl   o_ctl
);
    import tpst_pkg::*;

    t_step r_step;
    t_step n_step;
    t_ctl  w_ctl;

    function automatic logic cond_true(input t_cond c, input t_flags f);
        logic v;
        v = 1'b0;
        case (c)
            C_NEVER:     v = 1'b0;
            C_ALWAYS:    v = 1'b1;
            C_NO_INPUT:  v = f.no_input;
            C_UNKNOWN:   v = f.unknown;
            C_HIT:       v = f.hit;
            C_SCAN_BUSY: v = f.scan_busy;
            C_OUT_BUSY:  v = f.out_busy;
            default:     v = 1'b0;
        endcase
        return v;
    endfunction

    assign w_ctl = ctl_rom(r_step);
    assign o_ctl = w_ctl;

    always_comb begin
        if (cond_true(w_ctl.hold, i_flags)) begin
            n_step = r_step;
        end else if (cond_true(w_ctl.jump, i_flags)) begin
            n_step = w_ctl.target;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### design/tpst_checker.sv
// port-level checker for the session slot table, with its bind
// depends on tpst_pkg and two_party_session_slot_table_macros.svh
`timescale 1ns / 1ps
`include "two_party_session_slot_table_macros.svh"

module tpst_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic                           o_success,
    input logic [tpst_pkg::IDX_OUT_W-1:0] o_slot_index,
    input logic                           o_is_guest
);
    import tpst_pkg::*;

    // a stalled result word holds
    `TPST_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_success) && $stable(o_slot_index) && $stable(o_is_guest), "stalled result word changed")

    // a failed command reports a zero index and no guest flag
    `TPST_ASSERT_SAME(a_fail_zero, o_valid && !o_success, (o_slot_index == IDX_OUT_W'(0)) && !o_is_guest, "failure word not cleared")

    // the guest flag comes only with a found slot
    `TPST_ASSERT_SAME(a_guest_ok, o_valid && o_is_guest, o_success, "guest flag without success")

    // one command at a time: the input closes right after a word is taken
    `TPST_ASSERT_NEXT(a_one_cmd, i_valid && !o_stall, o_stall, "second command taken back to back")

endmodule

bind two_party_session_slot_table tpst_checker u_tpst_checker (.*);

### verif/two_party_session_slot_table_tb.sv
// testbench for the two-party session slot table: directed, capacity, random and
// backpressure tests, checked against an in-bench model of the slot table
// depends on tpst_pkg and two_party_session_slot_table
`timescale 1ns / 1ps

module two_party_session_slot_table_tb;

    import tpst_pkg::*;

    localparam int SLOTS       = NUM_SLOTS_DEF;
    localparam int ID_POOL     = 20;
    localparam int MAX_WAIT    = 18;
    localparam int LONG_HOLD   = 200;
    localparam int DRAIN_TAIL  = 40;
    localparam int CYCLE_LIMIT = 600000;

    // command codes the block does not know
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic                 success;
        logic [IDX_OUT_W-1:0] slot_index;
        logic                 is_guest;
    } t_slot_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [CMD_W-1:0]     i_command;
    logic [PID_W-1:0]     i_player_id;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_success;
    logic [IDX_OUT_W-1:0] o_slot_index;
    logic                 o_is_guest;

    two_party_session_slot_table dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_player_id  (i_player_id),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_success    (o_success),
        .o_slot_index (o_slot_index),
        .o_is_guest   (o_is_guest)
    );

    always #2 i_clk = ~i_clk;

    // model of the slot table, updated once per accepted command word
    t_slot_st     table_status [SLOTS];
    logic [15:0]  table_owner  [SLOTS];
    logic [15:0]  table_guest  [SLOTS];

    // results still owed by the block, oldest first
    t_slot_result pending_results[$];

    // idling knobs for the sender (tx) and the receiver (rx)
    int unsigned  tx_max_wait = MAX_WAIT;
    int unsigned  rx_max_wait = MAX_WAIT;
    int unsigned  rx_hold_req = 0;

    logic [15:0]  id_pool [ID_POOL];

    int unsigned  cycle_count    = 0;
    int unsigned  error_count    = 0;
    int unsigned  words_sent     = 0;
    int unsigned  words_checked  = 0;
    int unsigned  hits_seen      = 0;
    int unsigned  guest_hits     = 0;
    int unsigned  cmd_count [8];

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic void clear_table();
        for (int i = 0; i < SLOTS; i++) begin
            table_status[i] = ST_EMPTY;
            table_owner[i]  = '0;
            table_guest[i]  = '0;
        end
    endfunction

    // apply one command to the model and return the result it must produce
    function automatic t_slot_result table_apply(input logic [CMD_W-1:0] cmd,
                                                 input logic [15:0] id);
        t_slot_result r;
        int           hit_slot;
        logic         hit_guest;
        hit_slot  = -1;
        hit_guest = 1'b0;
        case (cmd)
            CMD_CREATE: begin
                for (int i = 0; i < SLOTS && hit_slot < 0; i++)
                    if (table_status[i] == ST_EMPTY) hit_slot = i;
                if (hit_slot >= 0) begin
                    table_owner[hit_slot]  = id;
                    table_status[hit_slot] = ST_WAITING;
                end
            end
            CMD_JOIN: begin
                for (int i = 0; i < SLOTS && hit_slot < 0; i++)
                    if (table_status[i] == ST_WAITING) hit_slot = i;
                if (hit_slot >= 0) begin
                    table_guest[hit_slot]  = id;
                    table_status[hit_slot] = ST_FULL;
                end
            end
            CMD_ROLE, CMD_FIND, CMD_LEAVE: begin
                // owner before guest within a slot, lowest slot first
                for (int i = 0; i < SLOTS && hit_slot < 0; i++) begin
                    if (table_status[i] != ST_EMPTY && table_owner[i] == id) begin
                        hit_slot = i;
                    end else if (table_status[i] == ST_FULL && table_guest[i] == id) begin
                        hit_slot  = i;
                        hit_guest = 1'b1;
                    end
                end
                if (cmd != CMD_ROLE) hit_guest = 1'b0;
                if (cmd == CMD_LEAVE && hit_slot >= 0) begin
                    table_status[hit_slot] = ST_EMPTY;
                    table_owner[hit_slot]  = '0;
                    table_guest[hit_slot]  = '0;
                end
            end
            default: ;
        endcase
        if (hit_slot >= 0) begin
            r.success    = 1'b1;
            r.slot_index = hit_slot[IDX_OUT_W-1:0];
            r.is_guest   = hit_guest;
        end else begin
            r = '0;
        end
        return r;
    endfunction

    // offer one command word, wait for it to be taken, then log its result
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [15:0] id);
        int unsigned gap;
        gap = $urandom_range(tx_max_wait, 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_player_id <= id;
        do @(posedge i_clk); while (o_stall);
        // word taken at this edge
        pending_results.push_back(table_apply(cmd, id));
        cmd_count[cmd]++;
        words_sent++;
    endtask

    // sender pause: nothing offered until every owed result is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void refresh_pool();
        for (int i = 0; i < ID_POOL; i++) id_pool[i] = 16'($urandom());
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 24)      return CMD_CREATE;
        else if (r < 44) return CMD_JOIN;
        else if (r < 58) return CMD_ROLE;
        else if (r < 72) return CMD_FIND;
        else if (r < 95) return CMD_LEAVE;
        else             return CMD_W'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
    endfunction

    // mostly ids from a small pool so finds and leaves hit, some pure noise
    function automatic logic [15:0] pick_id();
        if ($urandom_range(9, 0) == 0) return 16'($urandom());
        return id_pool[$urandom_range(ID_POOL - 1, 0)];
    endfunction

    // hand-picked sequence: sentinel, match order, duplicates, unknown codes
    task automatic test_directed();
        // empty table: id zero must not match the cleared fields
        send_word(CMD_FIND,   16'h0000);
        send_word(CMD_ROLE,   16'h0000);
        send_word(CMD_LEAVE,  16'h0000);
        send_word(CMD_JOIN,   16'hAAAA);
        send_word(CMD_CREATE, 16'h0000);
        send_word(CMD_CREATE, 16'hFFFF);
        // same id is guest of slot 0 and owner of slot 1: slot 0 wins
        send_word(CMD_JOIN,   16'hFFFF);
        send_word(CMD_ROLE,   16'hFFFF);
        send_word(CMD_ROLE,   16'h0000);
        send_word(CMD_FIND,   16'hFFFF);
        send_word(CMD_JOIN,   16'h1234);
        send_word(CMD_JOIN,   16'hAAAA);
        send_word(CMD_LEAVE,  16'hFFFF);
        send_word(CMD_FIND,   16'hFFFF);
        send_word(CMD_ROLE,   16'h1234);
        send_word(CMD_CREATE, 16'h0000);
        send_word(CMD_LEAVE,  16'h0000);
        send_word(CMD_CREATE, 16'h5555);
        send_word(CMD_RSVD_FIRST, 16'hFFFF);
        send_word(CMD_RSVD_FIRST + 3'd1, 16'h5555);
        send_word(CMD_RSVD_LAST, 16'h0000);
        send_word(CMD_FIND,   16'h5555);
        send_word(CMD_LEAVE,  16'h1234);
        send_word(CMD_LEAVE,  16'h5555);
    endtask

    // fill every slot, overflow create and join, then empty the table again
    task automatic test_capacity();
        logic [15:0] owners [SLOTS + 1];
        for (int i = 0; i <= SLOTS; i++) begin
            owners[i] = 16'($urandom());
            send_word(CMD_CREATE, owners[i]);
        end
        for (int i = 0; i <= SLOTS; i++) send_word(CMD_JOIN, 16'($urandom()));
        for (int i = SLOTS - 1; i >= 0; i -= 3) send_word(CMD_ROLE, owners[i]);
        for (int i = 0; i < SLOTS; i++) send_word(CMD_LEAVE, owners[i]);
        // last one never got a slot
        send_word(CMD_FIND, owners[SLOTS]);
    endtask

    task automatic test_random_traffic(input int unsigned n_words,
                                       input int unsigned tx_max,
                                       input int unsigned rx_max);
        tx_max_wait = tx_max;
        rx_max_wait = rx_max;
        refresh_pool();
        for (int unsigned k = 0; k < n_words; k++) send_word(pick_command(), pick_id());
        tx_max_wait = MAX_WAIT;
        rx_max_wait = MAX_WAIT;
    endtask

    // receiver holds off for a long stretch while words keep coming back to back
    task automatic test_backpressure();
        tx_max_wait = 0;
        rx_hold_req = LONG_HOLD;
        for (int k = 0; k < 12; k++) send_word(pick_command(), pick_id());
        tx_max_wait = MAX_WAIT;
    endtask

    // result side: random stall per word, long hold on request, field checks
    initial begin
        int unsigned  held;
        t_slot_result want;
        i_stall <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold_req > 0) begin
                held        = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                held = $urandom_range(rx_max_wait, 0);
            end
            if (held > 0) begin
                i_stall <= 1'b1;
                repeat (held) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            // word taken at this edge
            words_checked++;
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_success !== want.success)
                    report_mismatch($sformatf("success got %b want %b",
                                              o_success, want.success));
                if (o_slot_index !== want.slot_index)
                    report_mismatch($sformatf("slot_index got %0d want %0d",
                                              o_slot_index, want.slot_index));
                if (o_is_guest !== want.is_guest)
                    report_mismatch($sformatf("is_guest got %b want %b",
                                              o_is_guest, want.is_guest));
                if (want.success) hits_seen++;
                if (want.is_guest) guest_hits++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        foreach (cmd_count[c]) cmd_count[c] = 0;
        clear_table();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_command   <= CMD_CREATE;
        i_player_id <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_capacity();
        test_random_traffic(400, MAX_WAIT, MAX_WAIT);
        test_backpressure();
        // no idling on either side
        test_random_traffic(250, 0, 0);
        wait_drained();
        test_random_traffic(250, MAX_WAIT, 2);
        test_backpressure();
        test_random_traffic(250, 2, MAX_WAIT);

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("sent %0d words: create %0d, join %0d, role %0d, find %0d, leave %0d",
                 words_sent, cmd_count[CMD_CREATE], cmd_count[CMD_JOIN],
                 cmd_count[CMD_ROLE], cmd_count[CMD_FIND], cmd_count[CMD_LEAVE]);
        $display("checked %0d results, %0d hits, %0d guest matches, %0d mismatches",
                 words_checked, hits_seen, guest_hits, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
